@@ rtl/core/phong_pkg.sv @@
// shared types and constants of the point light phong shader
// depends on nothing; used by phong_datapath, phong_point_light_shading_top and tb
package phong_pkg;

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [16:0] OUT_MAX = 17'd98304;

  typedef enum logic [2:0] {
    REG_LIGHT_POSITION = 3'd0,
    REG_LIGHT_COLOR    = 3'd1,
    REG_LIGHT_RATIO    = 3'd2,
    REG_AMBIENT_COLOR  = 3'd3,
    REG_AMBIENT_RATIO  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [59:0] hit_position;
    logic [47:0] surface_normal;
    logic [47:0] view_direction;
    logic [47:0] surface_color;
    logic        occluder_found;
    logic [23:0] occluder_distance;
  } in_t;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
  } out_t;

  // ratios are already clamped to 1.0
  typedef struct packed {
    logic [59:0] light_position;
    logic [47:0] light_color;
    logic [15:0] light_ratio;
    logic [47:0] ambient_color;
    logic [15:0] ambient_ratio;
  } cfg_t;

endpackage

@@ rtl/core/phong_datapath.sv @@
// shading pipeline: light vector, pipelined square root and divider, dots,
// specular power and color sums; depends on phong_pkg
module phong_datapath #(
  parameter int SPECULAR_EXPONENT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  phong_pkg::in_t    in_data,
  input  phong_pkg::cfg_t   cfg,
  output logic              out_valid,
  input  logic              out_stall,
  output phong_pkg::out_t   out_data
);

  localparam int PW_LAST = 57 + SPECULAR_EXPONENT;
  localparam int MIX     = 58 + SPECULAR_EXPONENT;
  localparam int NST     = 60 + SPECULAR_EXPONENT;

  typedef struct packed {
    logic [2:0][20:0] d;
    logic [2:0][15:0] nv;
    logic [2:0][15:0] vv;
    logic [2:0][15:0] sc;
    logic             occ_found;
    logic [23:0]      occ_dist;
    logic [2:0][41:0] sq;
    logic [47:0]      occ2;
    logic [41:0]      dist2;
    logic [61:0]      x;
    logic [31:0]      srem;
    logic [30:0]      root;
    logic [2:0][45:0] drem;
    logic [2:0][14:0] q;
    logic [2:0][16:0] lv;
    logic [2:0][32:0] prod;
    logic [32:0]      dot28;
    logic             shadowed;
    logic             lit;
    logic [15:0]      ndl;
    logic [18:0]      dot14;
    logic [2:0][34:0] m;
    logic [2:0][36:0] r28;
    logic [2:0][52:0] rv;
    logic [54:0]      rd42;
    logic [15:0]      rd;
    logic [15:0]      spf;
    logic             spec;
    logic [2:0][16:0] t1;
    logic [2:0][16:0] e1;
    logic [2:0][16:0] l1;
    logic [2:0][16:0] amb;
    logic [2:0][16:0] eff;
    logic [2:0][16:0] de;
    logic [2:0][16:0] sp;
    logic [2:0][16:0] rgb;
  } pipe_t;

  function automatic logic [16:0] mulq15(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] pr;
    pr = a * b;
    return pr[31:15];
  endfunction

  function automatic pipe_t load(input phong_pkg::in_t di, input phong_pkg::cfg_t c);
    pipe_t p;
    logic signed [20:0] lp;
    logic signed [20:0] hp;
    p = '0;
    for (int k = 0; k < 3; k++) begin
      lp = $signed(c.light_position[20*k +: 20]);
      hp = $signed(di.hit_position[20*k +: 20]);
      p.d[k]  = lp - hp;
      p.nv[k] = di.surface_normal[16*k +: 16];
      p.vv[k] = di.view_direction[16*k +: 16];
      p.sc[k] = di.surface_color[16*k +: 16];
    end
    p.occ_found = di.occluder_found;
    p.occ_dist  = di.occluder_distance;
    return p;
  endfunction

  function automatic pipe_t step(input int s, input pipe_t pi, input phong_pkg::cfg_t c);
    pipe_t p;
    logic signed [41:0] sqv;
    logic [41:0]        acc2;
    logic [1:0]         pair;
    logic [33:0]        rem_sh;
    logic [33:0]        trial;
    logic [45:0]        cmp;
    logic [19:0]        mag;
    logic signed [16:0] qs;
    logic signed [32:0] prv;
    logic signed [32:0] acc28;
    logic signed [32:0] rnd14;
    logic signed [34:0] mv;
    logic signed [36:0] mm;
    logic signed [36:0] ll;
    logic signed [52:0] rvv;
    logic signed [54:0] acc42;
    logic [54:0]        rnd27;
    logic [27:0]        rdw;
    logic [32:0]        pw;
    logic [18:0]        sum;
    p = pi;
    if (s == 1) begin
      for (int k = 0; k < 3; k++) begin
        sqv = $signed(pi.d[k]) * $signed(pi.d[k]);
        p.sq[k] = sqv;
        p.t1[k] = mulq15({1'b0, pi.sc[k]}, {1'b0, c.ambient_color[16*k +: 16]});
        p.e1[k] = mulq15({1'b0, pi.sc[k]}, {1'b0, c.light_color[16*k +: 16]});
        p.l1[k] = mulq15({1'b0, c.light_color[16*k +: 16]}, {1'b0, c.light_ratio});
      end
      p.occ2 = pi.occ_dist * pi.occ_dist;
    end
    if (s == 2) begin
      acc2 = pi.sq[0] + pi.sq[1] + pi.sq[2];
      p.dist2 = acc2;
      p.x     = {acc2[41:0], 20'b0};
      p.srem  = '0;
      p.root  = '0;
      for (int k = 0; k < 3; k++) begin
        p.amb[k] = mulq15(pi.t1[k], {1'b0, c.ambient_ratio});
        p.eff[k] = mulq15(pi.e1[k], {1'b0, c.light_ratio});
      end
    end
    if (s == 3) begin
      p.shadowed = pi.occ_found && ({2'b00, pi.occ2} < {pi.dist2, 8'b0});
    end
    // square root, one result bit per stage
    if (s >= 3 && s <= 33) begin
      pair   = pi.x[61:60];
      p.x    = {pi.x[59:0], 2'b00};
      rem_sh = {1'b0, pi.srem[30:0], pair};
      trial  = {2'b00, pi.root[29:0], 2'b01};
      if (rem_sh >= trial) begin
        rem_sh = rem_sh - trial;
        p.root = {pi.root[29:0], 1'b1};
      end else begin
        p.root = {pi.root[29:0], 1'b0};
      end
      p.srem = rem_sh[31:0];
    end
    if (s == 34) begin
      for (int k = 0; k < 3; k++) begin
        mag = pi.d[k][20] ? 20'(-$signed(pi.d[k])) : pi.d[k][19:0];
        p.drem[k] = {2'b00, mag, 24'b0} + 46'(pi.root[30:1]);
        p.q[k]    = '0;
      end
    end
    // restoring divider, one quotient bit per stage
    if (s >= 35 && s <= 49) begin
      cmp = 46'(pi.root) << (49 - s);
      for (int k = 0; k < 3; k++) begin
        if (pi.drem[k] >= cmp) begin
          p.drem[k] = pi.drem[k] - cmp;
          p.q[k]    = {pi.q[k][13:0], 1'b1};
        end else begin
          p.q[k]    = {pi.q[k][13:0], 1'b0};
        end
      end
    end
    if (s == 50) begin
      for (int k = 0; k < 3; k++) begin
        qs = $signed({2'b00, pi.q[k]});
        if (pi.root == '0) begin
          p.lv[k] = '0;
        end else begin
          p.lv[k] = pi.d[k][20] ? -qs : qs;
        end
      end
    end
    if (s == 51) begin
      for (int k = 0; k < 3; k++) begin
        prv = $signed(pi.lv[k]) * $signed(pi.nv[k]);
        p.prod[k] = prv;
      end
    end
    if (s == 52) begin
      acc28 = $signed(pi.prod[0]) + $signed(pi.prod[1]) + $signed(pi.prod[2]);
      p.dot28 = acc28;
    end
    if (s == 53) begin
      p.lit = ($signed(pi.dot28) > 33'sd0) && !pi.shadowed;
      p.ndl = (pi.dot28[32:13] > 20'd32768) ? phong_pkg::ONE_Q15 : pi.dot28[28:13];
      rnd14 = $signed(pi.dot28) + 33'sd8192;
      p.dot14 = rnd14[32:14];
    end
    if (s == 54) begin
      for (int k = 0; k < 3; k++) begin
        mv = $signed(pi.dot14) * $signed(pi.nv[k]);
        p.m[k] = mv;
      end
    end
    if (s == 55) begin
      for (int k = 0; k < 3; k++) begin
        mm = $signed(pi.m[k]);
        ll = $signed(pi.lv[k]);
        p.r28[k] = (mm <<< 1) - (ll <<< 14);
      end
    end
    if (s == 56) begin
      for (int k = 0; k < 3; k++) begin
        rvv = $signed(pi.r28[k]) * $signed(pi.vv[k]);
        p.rv[k] = rvv;
      end
    end
    if (s == 57) begin
      acc42 = $signed(pi.rv[0]);
      acc42 = acc42 + $signed(pi.rv[1]);
      acc42 = acc42 + $signed(pi.rv[2]);
      p.rd42 = acc42;
    end
    if (s == 58) begin
      p.spec = pi.lit && ($signed(pi.rd42) > 55'sd0);
      rnd27  = pi.rd42 + 55'(64'd67108864);
      rdw    = rnd27[54:27];
      p.rd   = (rdw > 28'd32768) ? phong_pkg::ONE_Q15 : rdw[15:0];
      p.spf  = p.rd;
    end
    // specular power, one multiply per stage
    if (s >= 59 && s <= PW_LAST) begin
      pw    = pi.spf * pi.rd + 33'd16384;
      p.spf = pw[30:15];
    end
    if (s == MIX) begin
      for (int k = 0; k < 3; k++) begin
        p.de[k] = mulq15(pi.eff[k], {1'b0, pi.ndl});
        p.sp[k] = mulq15(pi.l1[k], {1'b0, pi.spf});
      end
    end
    if (s == MIX + 1) begin
      for (int k = 0; k < 3; k++) begin
        sum = 19'(pi.amb[k]);
        if (pi.lit) begin
          sum = sum + 19'(pi.de[k]);
        end
        if (pi.lit && pi.spec) begin
          sum = sum + 19'(pi.sp[k]);
        end
        p.rgb[k] = (sum > 19'(phong_pkg::OUT_MAX)) ? phong_pkg::OUT_MAX : sum[16:0];
      end
    end
    return p;
  endfunction

  pipe_t             p_r   [NST];
  pipe_t             p_nxt [NST];
  logic [NST-1:0]    v_r;
  logic [NST-1:0]    v_nxt;
  logic [NST:0]      rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign v_nxt    = {v_r[NST-2:0], in_valid};
  assign in_stall = !rdy[0];

  genvar gs;
  generate
    for (gs = 0; gs < NST; gs++) begin : g_stage
      if (gs == 0) begin : g_first
        always_comb begin
          p_nxt[gs] = load(in_data, cfg);
        end
      end else begin : g_rest
        always_comb begin
          p_nxt[gs] = step(gs, p_r[gs-1], cfg);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[gs] <= 1'b0;
        end else if (rdy[gs]) begin
          v_r[gs] <= v_nxt[gs];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[gs]) begin
          p_r[gs] <= p_nxt[gs];
        end
      end
    end
  endgenerate

  assign out_valid      = v_r[NST-1];
  assign out_data.red   = p_r[NST-1].rgb[0];
  assign out_data.green = p_r[NST-1].rgb[1];
  assign out_data.blue  = p_r[NST-1].rgb[2];

endmodule

@@ rtl/core/phong_point_light_shading_top.sv @@
// top level of the point light phong shader: configuration registers and pipeline
// depends on phong_pkg and phong_datapath
//
// Takes one surface hit per clock while in_stall is low and returns one shaded
// color per hit, in order. The light vector length comes from a square root
// pipeline of 31 stages, one result bit each, the unit light vector from a
// divider of 15 stages, one quotient bit each, and the specular power from
// SPECULAR_EXPONENT - 1 multiply stages. Every stage holds only while the stage
// after it is full and stalled, so bubbles are squeezed out and new requests
// keep entering while a result waits at the output. The user must write
// configuration only while no request is in flight; the block itself does not
// enforce this. The configuration port is always ready.
module phong_point_light_shading_top #(
  parameter int SPECULAR_EXPONENT = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  phong_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output phong_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [59:0]      cfg_data
);

  logic [59:0]     light_position_r;
  logic [47:0]     light_color_r;
  logic [15:0]     light_ratio_r;
  logic [47:0]     ambient_color_r;
  logic [15:0]     ambient_ratio_r;
  phong_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_position_r <= '0;
      light_color_r    <= '0;
      light_ratio_r    <= phong_pkg::ONE_Q15;
      ambient_color_r  <= '0;
      ambient_ratio_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        phong_pkg::REG_LIGHT_POSITION: light_position_r <= cfg_data;
        phong_pkg::REG_LIGHT_COLOR:    light_color_r    <= cfg_data[47:0];
        phong_pkg::REG_LIGHT_RATIO:    light_ratio_r    <= cfg_data[15:0];
        phong_pkg::REG_AMBIENT_COLOR:  ambient_color_r  <= cfg_data[47:0];
        phong_pkg::REG_AMBIENT_RATIO:  ambient_ratio_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ratios clamp at 1.0
  always_comb begin
    cfg.light_position = light_position_r;
    cfg.light_color    = light_color_r;
    cfg.ambient_color  = ambient_color_r;
    cfg.light_ratio    = (light_ratio_r > phong_pkg::ONE_Q15) ? phong_pkg::ONE_Q15
                                                              : light_ratio_r;
    cfg.ambient_ratio  = (ambient_ratio_r > phong_pkg::ONE_Q15) ? phong_pkg::ONE_Q15
                                                                : ambient_ratio_r;
  end

  phong_datapath #(
    .SPECULAR_EXPONENT(SPECULAR_EXPONENT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb.sv @@
// self-checking testbench of the point light phong shader
// depends on phong_pkg and phong_point_light_shading_top; predicts each shaded
// colour in fixed point and compares it with the block output in request order
module tb;
  import phong_pkg::*;

  localparam int SPEC_EXP = 10;
  localparam int LATENCY = 60 + SPEC_EXP;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1100;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [59:0] cfg_data;

  phong_point_light_shading_top #(.SPECULAR_EXPONENT(SPEC_EXP)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the configuration registers
  logic [59:0] m_light_pos;
  logic [47:0] m_light_col;
  logic [15:0] m_light_ratio;
  logic [47:0] m_amb_col;
  logic [15:0] m_amb_ratio;

  out_t pending_colors[$];
  int errors = 0;
  int n_requests = 0;
  int n_colors = 0;
  int n_lit = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  initial begin
    clk = 0;
  end
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic out_t shade(in_t r);
    longint d[3], lv[3], nv[3], vv[3];
    longint dot28, dot14, rd42, r28, lp, hp, q;
    logic [63:0] dist2, len, x, b, mag, ndl, spf, rd, occ;
    logic [63:0] lrat, arat, sc, lc, ac, sum, eff;
    bit lit, spec, shadowed;
    out_t o;
    dist2 = 0; dot28 = 0; ndl = 0; spf = 0; spec = 0;
    lrat = (m_light_ratio > ONE_Q15) ? 64'(ONE_Q15) : 64'(m_light_ratio);
    arat = (m_amb_ratio > ONE_Q15) ? 64'(ONE_Q15) : 64'(m_amb_ratio);
    for (int k = 0; k < 3; k++) begin
      lp = longint'($signed(m_light_pos[20*k +: 20]));
      hp = longint'($signed(r.hit_position[20*k +: 20]));
      d[k] = lp - hp;
      dist2 += 64'(d[k] * d[k]);
      nv[k] = longint'($signed(r.surface_normal[16*k +: 16]));
      vv[k] = longint'($signed(r.view_direction[16*k +: 16]));
    end
    // integer square root of dist2 in Q.10
    x = dist2 << 20;
    len = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= len + b) begin
        x -= len + b;
        len = (len >> 1) + b;
      end else begin
        len >>= 1;
      end
      b >>= 2;
    end
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        lv[k] = 0;
      end else begin
        mag = 64'(d[k] < 0 ? -d[k] : d[k]);
        q = longint'(((mag << 24) + (len >> 1)) / len);
        lv[k] = d[k] < 0 ? -q : q;
      end
      dot28 += lv[k] * nv[k];
    end
    occ = 64'(r.occluder_distance);
    shadowed = r.occluder_found && (occ * occ < (dist2 << 8));
    lit = dot28 > 0 && !shadowed;
    if (lit) begin
      dot14 = (dot28 + 8192) >>> 14;
      rd42 = 0;
      ndl = 64'(dot28) >> 13;
      if (ndl > ONE_Q15) ndl = ONE_Q15;
      for (int k = 0; k < 3; k++) begin
        r28 = 2 * dot14 * nv[k] - lv[k] * 16384;
        rd42 += r28 * vv[k];
      end
      if (rd42 > 0) begin
        rd = (64'(rd42) + (64'd1 << 26)) >> 27;
        if (rd > ONE_Q15) rd = ONE_Q15;
        spf = rd;
        for (int i = 1; i < SPEC_EXP; i++) spf = (spf * rd + 16384) >> 15;
        spec = 1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      sc = 64'(r.surface_color[16*k +: 16]);
      lc = 64'(m_light_col[16*k +: 16]);
      ac = 64'(m_amb_col[16*k +: 16]);
      sum = (((sc * ac) >> 15) * arat) >> 15;
      if (lit) begin
        eff = (((sc * lc) >> 15) * lrat) >> 15;
        sum += (eff * ndl) >> 15;
        if (spec) sum += (((lc * lrat) >> 15) * spf) >> 15;
      end
      if (sum > OUT_MAX) sum = OUT_MAX;
      if (k == 0) o.red = sum[16:0];
      else if (k == 1) o.green = sum[16:0];
      else o.blue = sum[16:0];
    end
    if (lit) n_lit++;
    return o;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [59:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LIGHT_POSITION: m_light_pos = val;
      REG_LIGHT_COLOR: m_light_col = val[47:0];
      REG_LIGHT_RATIO: m_light_ratio = val[15:0];
      REG_AMBIENT_COLOR: m_amb_col = val[47:0];
      REG_AMBIENT_RATIO: m_amb_ratio = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic setup_light(logic [59:0] pos, logic [47:0] lcol, logic [15:0] lrat,
                             logic [47:0] acol, logic [15:0] arat);
    write_reg(REG_LIGHT_POSITION, pos);
    write_reg(REG_LIGHT_COLOR, 60'(lcol));
    write_reg(REG_LIGHT_RATIO, 60'(lrat));
    write_reg(REG_AMBIENT_COLOR, 60'(acol));
    write_reg(REG_AMBIENT_RATIO, 60'(arat));
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // send one request; has_exp gives a typed-in expected color for checking
  task automatic send(in_t r, bit has_exp, out_t exp_col);
    out_t pred;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    if (has_exp) pred = exp_col;
    else pred = shade(r);
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_colors.push_back(pred);
    n_requests++;
    @(negedge clk);
  endtask

  function automatic logic [47:0] vec16(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [59:0] pos20(int x, int y, int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  function automatic in_t rand_item();
    in_t r;
    r.hit_position = 60'({$urandom, $urandom});
    r.surface_normal = 48'({$urandom, $urandom});
    r.view_direction = 48'({$urandom, $urandom});
    r.surface_color = 48'({$urandom, $urandom});
    r.occluder_found = 1'($urandom_range(0, 1));
    r.occluder_distance = 24'($urandom);
    return r;
  endfunction

  // well formed hit: small scene, unit axis-ish normal
  function automatic in_t scene_item();
    in_t r;
    int s;
    s = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    r.hit_position = pos20($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                           $urandom_range(0, 4095) - 2048);
    case ($urandom_range(0, 2))
      0: r.surface_normal = vec16(s, 0, 0);
      1: r.surface_normal = vec16(0, s, 0);
      default: r.surface_normal = vec16(11585, 0, s > 0 ? 11585 : -11585);
    endcase
    case ($urandom_range(0, 2))
      0: r.view_direction = vec16(-s, 0, 0);
      1: r.view_direction = vec16(0, -s, 0);
      default: r.view_direction = vec16($urandom_range(0, 32767) - 16384,
                                        $urandom_range(0, 32767) - 16384, -9000);
    endcase
    r.surface_color = 48'({$urandom, $urandom});
    r.occluder_found = ($urandom_range(0, 3) == 0);
    r.occluder_distance = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 14));
    return r;
  endfunction

  // result checker and stall generator
  int stall_left = 0;
  always @(posedge clk) begin
    out_t exp_col;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        exp_col = pending_colors.pop_front();
        n_colors++;
        if (out_data.red !== exp_col.red) begin
          $error("red: expected %0d, actual %0d", exp_col.red, out_data.red);
          errors++;
        end
        if (out_data.green !== exp_col.green) begin
          $error("green: expected %0d, actual %0d", exp_col.green, out_data.green);
          errors++;
        end
        if (out_data.blue !== exp_col.blue) begin
          $error("blue: expected %0d, actual %0d", exp_col.blue, out_data.blue);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    in_t req;
    bit has_exp;
    out_t exp_col;
  } row_t;

  initial begin
    row_t rows[$];
    in_t r;
    out_t none;
    none = '0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = REG_LIGHT_POSITION;
    cfg_data = '0;
    m_light_pos = '0;
    m_light_col = '0;
    m_light_ratio = ONE_Q15;
    m_amb_col = '0;
    m_amb_ratio = '0;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // after reset: no light color, no ambient, so black
    r = '0;
    rows.push_back('{r, 1, none});
    r = '1;
    rows.push_back('{r, 1, none});
    foreach (rows[i]) send(rows[i].req, rows[i].has_exp, rows[i].exp_col);
    in_valid <= 0;
    wait_drained();

    // full white light overhead, full ambient, oversized ratios clamp
    setup_light(pos20(0, 0, 2560), '1, 16'hFFFF, '1, 16'hFFFF);
    rows.delete();
    // normal facing light, view straight down: lit without specular, saturates
    r = '0;
    r.surface_normal = vec16(0, 0, 16384);
    r.view_direction = vec16(0, 0, -16384);
    r.surface_color = '1;
    rows.push_back('{r, 1, '{17'd98304, 17'd98304, 17'd98304}});
    // light at the hit point: only ambient
    r.hit_position = pos20(0, 0, 2560);
    r.surface_color = vec16(16384, 0, 32768);
    rows.push_back('{r, 1, '{17'd32767, 17'd0, 17'd65535}});
    // occluder closer than light: shadowed, only ambient
    r.hit_position = '0;
    r.occluder_found = 1;
    r.occluder_distance = 24'h1000;
    rows.push_back('{r, 1, '{17'd32767, 17'd0, 17'd65535}});
    // occluder farther than light: lit
    r.occluder_distance = 24'hFFFFFF;
    rows.push_back('{r, 0, none});
    // normal facing away
    r.occluder_found = 0;
    r.surface_normal = vec16(0, 0, -16384);
    rows.push_back('{r, 1, '{17'd32767, 17'd0, 17'd65535}});
    // non-unit normal: dot clamps
    r.surface_normal = vec16(0, 0, 32767);
    rows.push_back('{r, 0, none});
    // extremes of position and direction
    r.hit_position = pos20(-524288, 524287, -524288);
    r.surface_normal = vec16(-32768, 32767, -32768);
    r.view_direction = vec16(32767, -32768, 32767);
    rows.push_back('{r, 0, none});
    r.hit_position = pos20(524287, -524288, 524287);
    rows.push_back('{r, 0, none});
    for (int i = 0; i < 6; i++) rows.push_back('{scene_item(), 0, none});
    foreach (rows[i]) send(rows[i].req, rows[i].has_exp, rows[i].exp_col);
    in_valid <= 0;
    wait_drained();

    // random phases, a fresh light each time
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setup_light(pos20(0, 0, 0), '0, 16'd0, '0, 16'd0);
        1: setup_light(pos20(524287, -524288, 524287), '1, 16'd32768, '1, 16'd32768);
        default: setup_light(pos20($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                                   $urandom_range(0, 8191) - 4096),
                             48'({$urandom, $urandom}), 16'($urandom_range(0, 40000)),
                             48'({$urandom, $urandom}), 16'($urandom_range(0, 40000)));
      endcase
      if (ph == 5) quiet = 1;
      for (int i = 0; i < N_RANDOM / 6; i++)
        send(($urandom_range(0, 4) == 0) ? rand_item() : scene_item(), 0, none);
      in_valid <= 0;
      wait_drained();
    end
    // unknown register index is ignored
    cfg_valid <= 1;
    cfg_index <= 3'd7;
    cfg_data <= '1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    send(scene_item(), 0, none);
    in_valid <= 0;
    wait_drained();

    $display("covered %0d requests, %0d colors checked, %0d lit by the point light",
             n_requests, n_colors, n_lit);
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/phong_pkg.sv
rtl/core/phong_datapath.sv
rtl/core/phong_point_light_shading_top.sv
verif/tb.sv
